FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl of the glyph positioner
// expects a clock named clk and a synchronous active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MGP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MGP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mgp_pkg.sv
// package for the math glyph positioner: item types, control word, codes,
// glyph tables and reciprocal constants; no dependencies
`default_nettype none

package mgp_pkg;

  // register indexes
  localparam logic [1:0] REG_FONT_SIZE  = 2'd0;
  localparam logic [1:0] REG_START_X    = 2'd1;
  localparam logic [1:0] REG_BASELINE_Y = 2'd2;

  localparam logic [22:0] FS_RESET = 23'd655360;

  // atom classes
  localparam logic [2:0] CLS_ORD   = 3'd0;
  localparam logic [2:0] CLS_BIN   = 3'd2;
  localparam logic [2:0] CLS_REL   = 3'd3;
  localparam logic [2:0] CLS_OPEN  = 3'd4;
  localparam logic [2:0] CLS_CLOSE = 3'd5;
  localparam logic [2:0] CLS_PUNCT = 3'd6;

  // fonts
  localparam logic [1:0] FONT_ROMAN  = 2'd0;
  localparam logic [1:0] FONT_ITALIC = 2'd1;
  localparam logic [1:0] FONT_SYMBOL = 2'd2;

  // multiplier operand selections
  localparam logic [2:0] MOP_NONE    = 3'd0;
  localparam logic [2:0] MOP_FS_R1E5 = 3'd1;
  localparam logic [2:0] MOP_QF_1E5  = 3'd2;
  localparam logic [2:0] MOP_MU_FS   = 3'd3;
  localparam logic [2:0] MOP_SP_R18  = 3'd4;
  localparam logic [2:0] MOP_N_QF    = 3'd5;
  localparam logic [2:0] MOP_N_RF    = 3'd6;
  localparam logic [2:0] MOP_R3125   = 3'd7;

  // pen operations
  localparam logic [2:0] PEN_HOLD   = 3'd0;
  localparam logic [2:0] PEN_START  = 3'd1;
  localparam logic [2:0] PEN_ADD_SP = 3'd2;
  localparam logic [2:0] PEN_ADD_T1 = 3'd3;
  localparam logic [2:0] PEN_ADD_T3 = 3'd4;

  // font size quotient and remainder by 100000
  localparam logic [1:0] DOP_NONE = 2'd0;
  localparam logic [1:0] DOP_QF   = 2'd1;
  localparam logic [1:0] DOP_RF   = 2'd2;

  // exact reciprocals: floor(x*m / 2**k) == floor(x / d) over the operand range
  localparam logic [23:0] RECIP_1E5  = 24'd10995117;   // k 40, x below 2**23
  localparam logic [16:0] K_1E5      = 17'd100000;
  localparam logic [26:0] RECIP_18   = 27'd119304648;  // k 31, x below 2**26
  localparam logic [29:0] RECIP_3125 = 30'd703687442;  // k 41, x below 2**29

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               glyph_valid;
    logic [7:0]         glyph_code;
    logic signed [31:0] glyph_x;
    logic signed [31:0] glyph_y;
    logic [1:0]         font_select;
    logic               end_of_expr;
    logic [30:0]        total_width;
  } out_item_t;

  typedef struct packed {
    logic [2:0] mop;
    logic [2:0] pen_op;
    logic [1:0] dop;
    logic       cap;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    logic dvalid;
    logic first;
    logic space;
    logic out_free;
  } stat_t;

  // glyph widths in thousandths of a unit, codes 32 to 127
  localparam logic [10:0] WIDTH_TAB [96] = '{
    11'd333, 11'd278, 11'd500, 11'd833, 11'd500, 11'd833, 11'd778, 11'd278,
    11'd389, 11'd389, 11'd500, 11'd778, 11'd278, 11'd778, 11'd278, 11'd500,
    11'd500, 11'd500, 11'd500, 11'd500, 11'd500, 11'd500, 11'd500, 11'd500,
    11'd500, 11'd500,
    11'd278, 11'd278, 11'd778, 11'd778, 11'd778, 11'd472,
    11'd778, 11'd750, 11'd708, 11'd722, 11'd764, 11'd681, 11'd653, 11'd785,
    11'd750, 11'd361, 11'd514, 11'd778, 11'd625, 11'd917, 11'd750, 11'd778,
    11'd681, 11'd778, 11'd736, 11'd556, 11'd722, 11'd750, 11'd750, 11'd1028,
    11'd750, 11'd750, 11'd611,
    11'd278, 11'd500, 11'd278, 11'd500, 11'd500, 11'd278,
    11'd500, 11'd556, 11'd444, 11'd556, 11'd444, 11'd306, 11'd500, 11'd556,
    11'd278, 11'd306, 11'd528, 11'd278, 11'd833, 11'd556, 11'd500, 11'd556,
    11'd528, 11'd392, 11'd394, 11'd389, 11'd556, 11'd528, 11'd722, 11'd528,
    11'd528, 11'd444,
    11'd480, 11'd200, 11'd480, 11'd500, 11'd0
  };

  // lowercase width times italic factor in percent
  localparam logic [16:0] LOWER_ADV [26] = '{
    17'd50000, 17'd55600, 17'd39960, 17'd55600, 17'd39960, 17'd26010,
    17'd50000, 17'd55600, 17'd22240, 17'd27540, 17'd52800, 17'd22240,
    17'd91630, 17'd55600, 17'd50000, 17'd55600, 17'd52800, 17'd37240,
    17'd35460, 17'd35010, 17'd55600, 17'd52800, 17'd72200, 17'd52800,
    17'd52800, 17'd44400
  };

  // inter-atom space in mu, rows previous class, columns current class
  localparam logic [2:0] SPACE_MU [8][8] = '{
    '{3'd0, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd3},
    '{3'd3, 3'd3, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd3},
    '{3'd4, 3'd4, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd4},
    '{3'd5, 3'd5, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd5},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd3},
    '{3'd3, 3'd3, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3},
    '{3'd3, 3'd3, 3'd4, 3'd5, 3'd3, 3'd0, 3'd3, 3'd3}
  };

  function automatic logic [2:0] classify(input logic [7:0] c);
    unique case (c)
      "+", "-", "*": return CLS_BIN;
      "=", "<", ">": return CLS_REL;
      "(", "[", "{": return CLS_OPEN;
      ")", "]", "}": return CLS_CLOSE;
      ",", ";":      return CLS_PUNCT;
      default:       return CLS_ORD;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // advance numerator over a divisor of 100000
  function automatic logic [16:0] adv_num(input logic [7:0] c);
    logic [6:0] wi;
    logic [4:0] li;
    wi = c[6:0] - 7'd32;
    li = 5'(c - 8'd97);
    if (c[7]) begin
      return 17'd50000;
    end else if (c < 8'd32) begin
      return 17'd0;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      return LOWER_ADV[li];
    end else begin
      return 17'(WIDTH_TAB[wi]) * 17'd100;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/math_glyph_positioner.sv
// math glyph positioner top level: config registers, datapath with one shared
// multiplier, output register; depends on mgp_pkg, mgp_useq, assert_macros.svh
// a new item is taken only once the previous one has been emitted, as in_stall is
// held high meanwhile; whitespace skips the pen advance steps
// the first item after a font_size write also runs the quotient and remainder by 100000
// every microcode step issues at most one product on the 29x30 multiplier
// rst_n is synchronous: sequencer idle, no result held, registers back to reset values
`default_nettype none
`include "assert_macros.svh"

module math_glyph_positioner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mgp_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mgp_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [22:0]        fs_r;
  logic signed [31:0] sx_r;
  logic signed [31:0] by_r;
  logic               dvalid_r;
  logic [6:0]         qf_r;
  logic [16:0]        rf_r;
  logic [7:0]         char_r;
  logic               last_r;
  logic               space_r;
  logic [2:0]         cls_r;
  logic [2:0]         prev_r;
  logic               first_r;
  logic [16:0]        n_r;
  logic [58:0]        prod_r;
  logic signed [31:0] pen_r, pen_nxt;
  logic signed [31:0] gx_r;
  logic               out_valid_r;
  mgp_pkg::out_item_t out_r, out_nxt;

  mgp_pkg::ctrl_t ctrl;
  mgp_pkg::stat_t st;
  logic           seq_busy;
  logic           cfg_wr;
  logic           in_accept;
  logic           out_free;
  logic           emit_go;
  logic           out_load;
  logic [28:0]    mul_a;
  logic [29:0]    mul_b;
  logic [58:0]    prod_w;
  logic [23:0]    add_v;
  logic [32:0]    pen_sum;
  logic [31:0]    pen_sat;
  logic [32:0]    diff;
  logic [30:0]    tw;
  logic [1:0]     font;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign in_stall  = seq_busy;
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign emit_go   = ctrl.emit & out_free;
  assign out_load  = emit_go & (~space_r | last_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign st.dvalid   = dvalid_r;
  assign st.first    = first_r;
  assign st.space    = space_r;
  assign st.out_free = out_free;

  mgp_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .st    (st),
    .ctrl  (ctrl),
    .busy  (seq_busy)
  );

  always_comb begin
    unique case (paddr[3:2])
      mgp_pkg::REG_FONT_SIZE:  prdata = {9'd0, fs_r};
      mgp_pkg::REG_START_X:    prdata = sx_r;
      mgp_pkg::REG_BASELINE_Y: prdata = by_r;
      default:                 prdata = 32'd0;
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mop)
      mgp_pkg::MOP_FS_R1E5: begin
        mul_a = 29'(fs_r);
        mul_b = 30'(mgp_pkg::RECIP_1E5);
      end
      mgp_pkg::MOP_QF_1E5: begin
        mul_a = 29'(prod_r[46:40]);
        mul_b = 30'(mgp_pkg::K_1E5);
      end
      mgp_pkg::MOP_MU_FS: begin
        mul_a = 29'(mgp_pkg::SPACE_MU[prev_r][cls_r]);
        mul_b = 30'(fs_r);
      end
      mgp_pkg::MOP_SP_R18: begin
        mul_a = 29'(prod_r[25:0]);
        mul_b = 30'(mgp_pkg::RECIP_18);
      end
      mgp_pkg::MOP_N_QF: begin
        mul_a = 29'(n_r);
        mul_b = 30'(qf_r);
      end
      mgp_pkg::MOP_N_RF: begin
        mul_a = 29'(n_r);
        mul_b = 30'(rf_r);
      end
      mgp_pkg::MOP_R3125: begin
        mul_a = prod_r[33:5];
        mul_b = mgp_pkg::RECIP_3125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = {30'd0, mul_a} * {29'd0, mul_b};

  // saturating pen update, addends are never negative
  always_comb begin
    case (ctrl.pen_op)
      mgp_pkg::PEN_ADD_SP: add_v = 24'(prod_r[52:31]);
      mgp_pkg::PEN_ADD_T1: add_v = prod_r[23:0];
      mgp_pkg::PEN_ADD_T3: add_v = 24'(prod_r[58:41]);
      default:             add_v = 24'd0;
    endcase
    pen_sum = {pen_r[31], pen_r} + {9'd0, add_v};
    pen_sat = (pen_sum[32] != pen_sum[31]) ? 32'h7FFF_FFFF : pen_sum[31:0];
    case (ctrl.pen_op)
      mgp_pkg::PEN_START:  pen_nxt = sx_r;
      mgp_pkg::PEN_ADD_SP,
      mgp_pkg::PEN_ADD_T1,
      mgp_pkg::PEN_ADD_T3: pen_nxt = pen_sat;
      default:             pen_nxt = pen_r;
    endcase
  end

  // total width and result item
  always_comb begin
    diff = {pen_r[31], pen_r} - {sx_r[31], sx_r};
    if (first_r && space_r) begin
      tw = 31'd0;
    end else if (diff[32]) begin
      tw = 31'd0;
    end else if (diff[31]) begin
      tw = 31'h7FFF_FFFF;
    end else begin
      tw = diff[30:0];
    end
    if (char_r >= "0" && char_r <= "9") begin
      font = mgp_pkg::FONT_ROMAN;
    end else if (cls_r == mgp_pkg::CLS_BIN || cls_r == mgp_pkg::CLS_REL) begin
      font = mgp_pkg::FONT_SYMBOL;
    end else begin
      font = mgp_pkg::FONT_ITALIC;
    end
    out_nxt = '0;
    out_nxt.end_of_expr = last_r;
    out_nxt.total_width = last_r ? tw : 31'd0;
    if (!space_r) begin
      out_nxt.glyph_valid = 1'b1;
      out_nxt.glyph_code  = char_r;
      out_nxt.glyph_x     = gx_r;
      out_nxt.glyph_y     = by_r;
      out_nxt.font_select = font;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r        <= mgp_pkg::FS_RESET;
      sx_r        <= '0;
      by_r        <= '0;
      dvalid_r    <= 1'b0;
      first_r     <= 1'b1;
      prev_r      <= mgp_pkg::CLS_ORD;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.dop == mgp_pkg::DOP_RF) begin
        dvalid_r <= 1'b1;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          mgp_pkg::REG_FONT_SIZE: begin
            fs_r     <= pwdata[22:0];
            dvalid_r <= 1'b0;
          end
          mgp_pkg::REG_START_X:    sx_r <= pwdata;
          mgp_pkg::REG_BASELINE_Y: by_r <= pwdata;
          default: begin
          end
        endcase
      end
      if (emit_go && !space_r) begin
        prev_r  <= cls_r;
        first_r <= 1'b0;
      end
      if (emit_go && last_r) begin
        prev_r  <= mgp_pkg::CLS_ORD;
        first_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_r  <= in_data.char_code;
      last_r  <= in_data.last;
      space_r <= mgp_pkg::is_space(in_data.char_code);
      cls_r   <= mgp_pkg::classify(in_data.char_code);
      n_r     <= mgp_pkg::adv_num(in_data.char_code);
    end
    if (ctrl.mop != mgp_pkg::MOP_NONE) begin
      prod_r <= prod_w;
    end
    if (ctrl.dop == mgp_pkg::DOP_QF) begin
      qf_r <= prod_r[46:40];
    end
    if (ctrl.dop == mgp_pkg::DOP_RF) begin
      rf_r <= 17'(fs_r - prod_r[22:0]);
    end
    if (ctrl.cap) begin
      gx_r <= pen_r;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
    pen_r <= pen_nxt;
  end

  `MGP_ASSERT_NXT(a_emit_hold, ctrl.emit && !out_free, ctrl.emit, "emit step left while slot full")
  `MGP_ASSERT_IMP(a_blank_is_end, out_valid_r && !out_r.end_of_expr, out_r.glyph_valid, "empty item mid expression")

endmodule

`default_nettype wire

FILE: rtl/mgp_useq.sv
// microcode sequencer of the glyph positioner: step counter, control rom, jumps
// depends on mgp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mgp_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire mgp_pkg::stat_t st,
  output mgp_pkg::ctrl_t     ctrl,
  output logic               busy
);

  localparam logic [3:0] STEP_D0    = 4'd0;
  localparam logic [3:0] STEP_D1    = 4'd1;
  localparam logic [3:0] STEP_D2    = 4'd2;
  localparam logic [3:0] STEP_DISP  = 4'd3;
  localparam logic [3:0] STEP_FCHK  = 4'd4;
  localparam logic [3:0] STEP_SPADD = 4'd5;
  localparam logic [3:0] STEP_FIRST = 4'd6;
  localparam logic [3:0] STEP_T1    = 4'd7;
  localparam logic [3:0] STEP_RED   = 4'd8;
  localparam logic [3:0] STEP_T3    = 4'd9;
  localparam logic [3:0] STEP_EMIT  = 4'd10;
  localparam logic [3:0] STEP_LAST  = STEP_EMIT;

  localparam logic [2:0] JC_NONE   = 3'd0;
  localparam logic [2:0] JC_ALWAYS = 3'd1;
  localparam logic [2:0] JC_DVALID = 3'd2;
  localparam logic [2:0] JC_FIRST  = 3'd3;
  localparam logic [2:0] JC_SPACE  = 3'd4;

  typedef struct packed {
    mgp_pkg::ctrl_t c;
    logic [2:0]     jc;
    logic [3:0]     jt;
  } uword_t;

  function automatic uword_t rom(input logic [3:0] a);
    uword_t w;
    w = '0;
    unique case (a)
      STEP_D0: begin
        w.c.mop = mgp_pkg::MOP_FS_R1E5;
        w.jc    = JC_DVALID;
        w.jt    = STEP_DISP;
      end
      STEP_D1: begin
        w.c.mop = mgp_pkg::MOP_QF_1E5;
        w.c.dop = mgp_pkg::DOP_QF;
      end
      STEP_D2: begin
        w.c.dop = mgp_pkg::DOP_RF;
      end
      STEP_DISP: begin
        w.c.mop = mgp_pkg::MOP_MU_FS;
        w.jc    = JC_SPACE;
        w.jt    = STEP_EMIT;
      end
      STEP_FCHK: begin
        w.c.mop = mgp_pkg::MOP_SP_R18;
        w.jc    = JC_FIRST;
        w.jt    = STEP_FIRST;
      end
      STEP_SPADD: begin
        w.c.mop    = mgp_pkg::MOP_N_QF;
        w.c.pen_op = mgp_pkg::PEN_ADD_SP;
        w.jc       = JC_ALWAYS;
        w.jt       = STEP_T1;
      end
      STEP_FIRST: begin
        w.c.mop    = mgp_pkg::MOP_N_QF;
        w.c.pen_op = mgp_pkg::PEN_START;
      end
      STEP_T1: begin
        w.c.mop    = mgp_pkg::MOP_N_RF;
        w.c.pen_op = mgp_pkg::PEN_ADD_T1;
        w.c.cap    = 1'b1;
      end
      STEP_RED: begin
        w.c.mop = mgp_pkg::MOP_R3125;
      end
      STEP_T3: begin
        w.c.pen_op = mgp_pkg::PEN_ADD_T3;
      end
      STEP_EMIT: begin
        w.c.emit = 1'b1;
      end
      default: begin
        w.jc = JC_ALWAYS;
        w.jt = STEP_EMIT;
      end
    endcase
    return w;
  endfunction

  logic [3:0] pc_r, pc_nxt;
  logic       busy_r, busy_nxt;
  uword_t     uw;
  logic       taken;

  always_comb begin
    uw = rom(pc_r);
    unique case (uw.jc)
      JC_NONE:   taken = 1'b0;
      JC_ALWAYS: taken = 1'b1;
      JC_DVALID: taken = st.dvalid;
      JC_FIRST:  taken = st.first;
      JC_SPACE:  taken = st.space;
      default:   taken = 1'b0;
    endcase
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = STEP_D0;
      end
    end else if (uw.c.emit) begin
      if (st.out_free) begin
        busy_nxt = 1'b0;
        pc_nxt   = STEP_D0;
      end
    end else begin
      pc_nxt = taken ? uw.jt : pc_r + 4'd1;
    end
  end

  assign ctrl = busy_r ? uw.c : '0;
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= STEP_D0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  `MGP_ASSERT_IMP(a_pc_range, busy_r, pc_r <= STEP_LAST, "step counter beyond program")
  `MGP_ASSERT_IMP(a_done_at_emit, $fell(busy_r), $past(pc_r) == STEP_EMIT, "item ended off emit")

endmodule

`default_nettype wire
